// ----- rtl/core/ktrgb_pkg.sv -----
// Shared types and constants for the color temperature to RGB converter.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ktrgb_pkg;

   localparam int unsigned NumChan    = 3;
   localparam int unsigned KelvinWarm = 2700;
   localparam int unsigned KelvinCool = 6500;
   localparam int unsigned KelvinSpan = KelvinCool - KelvinWarm;

   // width of the clamped offset from the warm end (0..3800)
   localparam int unsigned CoolWidth  = $clog2(KelvinSpan + 1);
   // weighted sum before the divide by the span, max 255*3800 + 1900
   localparam int unsigned AccWidth   = 20;

   // acc / 3800 == (acc * MixRecip) >> MixShift, exact for acc < 2**20
   localparam int unsigned MixShift      = 32;
   localparam int unsigned MixRecipWidth = 21;
   localparam logic [MixRecipWidth-1:0] MixRecip = 21'd1130255;
   localparam int unsigned MixProdWidth  = AccWidth + MixRecipWidth;

   // p / 255 == (p * Div255Recip) >> Div255Shift, exact for p <= 255*255
   localparam int unsigned Div255Shift      = 24;
   localparam int unsigned Div255RecipWidth = 17;
   localparam logic [Div255RecipWidth-1:0] Div255Recip = 17'd65794;
   localparam int unsigned Div255ProdWidth  = 16 + Div255RecipWidth;

   // endpoints, index 0 red, 1 green, 2 blue
   localparam logic [7:0] WarmEnd [NumChan] = '{8'd255, 8'd180, 8'd100};
   localparam logic [7:0] CoolEnd [NumChan] = '{8'd205, 8'd225, 8'd255};

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   typedef enum logic {
      ModeApprox = 1'b0,
      ModeMax    = 1'b1
   } ktrgb_mode_type;

   // one classified pixel passed from front to back
   typedef struct packed {
      ktrgb_mode_type              mode;
      logic [7:0]                  bright;
      logic [NumChan-1:0][7:0]     mix;
   } ktrgb_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/kelvin_to_rgb_color.sv -----
// Top level of the color temperature to RGB converter.
// Instantiates ktrgb_front, ktrgb_queue and ktrgb_back; uses ktrgb_pkg.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   request | req_valid req_stall req_type req_kelvin       | in
//           | req_brightness                                |
//   result  | rsp_valid rsp_stall rsp_red rsp_green rsp_blue| out
//
// Throughput: one transaction per clock while rsp_stall is low, each stage of both
// pipelines is a single register with a ready chain, so items follow back to back.
// Path: a request passes the three front stages, one queue slot and the four
// back stages incl. the output register before rsp_valid rises.
// Reset (synchronous, active high) only empties the pipelines and the queue.
// A stall on rsp_ fills the back stages, then the four-entry queue, then the
// front; req_stall rises only once all of that is full.
`default_nettype none

module kelvin_to_rgb_color import ktrgb_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_type,
   input  wire logic [15:0]  req_kelvin,
   input  wire logic [7:0]   req_brightness,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue
);

   // front -> queue
   logic            fq_valid, fq_ready;
   ktrgb_item_type  fq_item;
   // queue -> back
   logic            qb_valid, qb_ready;
   ktrgb_item_type  qb_item;

   // clamp + interpolation, classified by mode
   ktrgb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (ktrgb_mode_type'(req_type)),
      .req_kelvin     (req_kelvin),
      .req_brightness (req_brightness),
      .out_valid      (fq_valid),
      .out_ready      (fq_ready),
      .out_item       (fq_item)
   );

   // decouples front from output stalls
   ktrgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   // brightness scaling or max stretch + video scaling
   ktrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_item   (qb_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule

`default_nettype wire

// ----- rtl/core/ktrgb_front.sv -----
// Front end: accepts pixels, clamps kelvin, interpolates the three channels.
// Three register stages; depends on ktrgb_pkg.
`default_nettype none

module ktrgb_front import ktrgb_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire ktrgb_mode_type  req_mode,
   input  wire logic [15:0]     req_kelvin,
   input  wire logic [7:0]      req_brightness,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output ktrgb_item_type       out_item
);

   logic f1_valid_ff, f1_valid_in;
   logic f2_valid_ff, f2_valid_in;
   logic f3_valid_ff, f3_valid_in;
   logic rdy1, rdy2, rdy3;

   ktrgb_mode_type         f1_mode_ff, f2_mode_ff;
   logic [7:0]             f1_bright_ff, f2_bright_ff;
   logic [CoolWidth-1:0]   f1_cool_ff, cool_in;
   logic [AccWidth-1:0]    f2_acc_ff [NumChan];
   logic [AccWidth-1:0]    acc_in [NumChan];
   logic [CoolWidth-1:0]   warm_w;
   ktrgb_item_type         f3_item_ff, item_in;
   logic [MixProdWidth-1:0] prod [NumChan];

   always_comb begin
      rdy3 = !f3_valid_ff || out_ready;
      rdy2 = !f2_valid_ff || rdy3;
      rdy1 = !f1_valid_ff || rdy2;
      req_stall = !rdy1;
      f1_valid_in = rdy1 ? req_valid   : f1_valid_ff;
      f2_valid_in = rdy2 ? f1_valid_ff : f2_valid_ff;
      f3_valid_in = rdy3 ? f2_valid_ff : f3_valid_ff;
   end

   // clamp to the warm..cool range and take the offset from the warm end
   always_comb begin
      if (req_kelvin < 16'(KelvinWarm)) begin
         cool_in = '0;
      end else if (req_kelvin > 16'(KelvinCool)) begin
         cool_in = CoolWidth'(KelvinSpan);
      end else begin
         cool_in = CoolWidth'(req_kelvin - 16'(KelvinWarm));
      end
   end

   // weighted sum with half-span rounding bias
   always_comb begin
      warm_w = CoolWidth'(KelvinSpan) - f1_cool_ff;
      for (int i = 0; i < NumChan; i++) begin
         acc_in[i] = AccWidth'(WarmEnd[i]) * AccWidth'(warm_w)
                   + AccWidth'(CoolEnd[i]) * AccWidth'(f1_cool_ff)
                   + AccWidth'(KelvinSpan / 2);
      end
   end

   // divide by the span through a reciprocal
   always_comb begin
      item_in.mode   = f2_mode_ff;
      item_in.bright = f2_bright_ff;
      for (int i = 0; i < NumChan; i++) begin
         prod[i] = MixProdWidth'(f2_acc_ff[i]) * MixProdWidth'(MixRecip);
         item_in.mix[i] = prod[i][MixShift +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f2_valid_in;
         f3_valid_ff <= f3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         f1_mode_ff   <= req_mode;
         f1_bright_ff <= req_brightness;
         f1_cool_ff   <= cool_in;
      end
      if (rdy2) begin
         f2_mode_ff   <= f1_mode_ff;
         f2_bright_ff <= f1_bright_ff;
         f2_acc_ff    <= acc_in;
      end
      if (rdy3) begin
         f3_item_ff <= item_in;
      end
   end

   assign out_valid = f3_valid_ff;
   assign out_item  = f3_item_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ktrgb_queue.sv -----
// Short FIFO between front and back end, QueueDepth entries.
// Depends on ktrgb_pkg for the item type and depth.
`default_nettype none

module ktrgb_queue import ktrgb_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire ktrgb_item_type  in_item,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output ktrgb_item_type       out_item
);

   ktrgb_item_type         entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;
   logic                   push, pop;

   always_comb begin
      in_ready  = count_ff != (QueuePtrW + 1)'(QueueDepth);
      out_valid = count_ff != '0;
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QueuePtrW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QueuePtrW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign out_item = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- rtl/core/ktrgb_back.sv -----
// Back end: brightness scaling, or max stretch plus video scaling.
// Four register stages, the last one is the output register; uses ktrgb_pkg.
`default_nettype none

module ktrgb_back import ktrgb_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire ktrgb_item_type  in_item,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue
);

   logic b1_valid_ff, b1_valid_in;
   logic b2_valid_ff, b2_valid_in;
   logic b3_valid_ff, b3_valid_in;
   logic b4_valid_ff, b4_valid_in;
   logic rdy1, rdy2, rdy3, rdy4;

   ktrgb_mode_type  b1_mode_ff, b2_mode_ff, b3_mode_ff;
   logic [7:0]      b1_bright_ff, b2_bright_ff, b3_bright_ff;
   logic [15:0]     b1_num_ff [NumChan];
   logic [15:0]     num_in [NumChan];
   logic [7:0]      b1_max_ff, max_in;
   logic [7:0]      b2_max_ff;
   logic [7:0]      b2_apx_ff [NumChan];
   logic [7:0]      apx_in [NumChan];
   logic [7:0]      b2_rem_ff [NumChan];
   logic [7:0]      rem_in [NumChan];
   logic [3:0]      b2_qhi_ff [NumChan];
   logic [3:0]      qhi_in [NumChan];
   logic [3:0]      b2_nlo_ff [NumChan];
   logic [3:0]      nlo_in [NumChan];
   logic [11:0]     hi_step [NumChan];
   logic [11:0]     lo_step [NumChan];
   logic [7:0]      b3_val_ff [NumChan];
   logic [7:0]      val_in [NumChan];
   logic [7:0]      b4_out_ff [NumChan];
   logic [7:0]      out_in [NumChan];
   logic [Div255ProdWidth-1:0] scale_prod [NumChan];
   logic [15:0]     video_prod [NumChan];

   // four restoring divide steps, returns {remainder, quotient bits}
   // partial remainder in is below den, so the full quotient fits 8 bits
   function automatic logic [11:0] div_steps(input logic [7:0] rem_start,
                                             input logic [3:0] bits,
                                             input logic [7:0] den);
      logic [8:0] rem;
      logic [3:0] quot;
      rem  = {1'b0, rem_start};
      quot = '0;
      for (int j = 3; j >= 0; j--) begin
         rem = {rem[7:0], bits[j]};
         if (rem >= {1'b0, den}) begin
            rem     = rem - {1'b0, den};
            quot[j] = 1'b1;
         end
      end
      return {rem[7:0], quot};
   endfunction

   always_comb begin
      rdy4 = !b4_valid_ff || !rsp_stall;
      rdy3 = !b3_valid_ff || rdy4;
      rdy2 = !b2_valid_ff || rdy3;
      rdy1 = !b1_valid_ff || rdy2;
      in_ready = rdy1;
      b1_valid_in = rdy1 ? in_valid    : b1_valid_ff;
      b2_valid_in = rdy2 ? b1_valid_ff : b2_valid_ff;
      b3_valid_in = rdy3 ? b2_valid_ff : b3_valid_ff;
      b4_valid_in = rdy4 ? b3_valid_ff : b4_valid_ff;
   end

   // stage 1: product with brightness, or mix*255 and the channel maximum
   always_comb begin
      max_in = in_item.mix[0];
      if (in_item.mix[1] > max_in) begin
         max_in = in_item.mix[1];
      end
      if (in_item.mix[2] > max_in) begin
         max_in = in_item.mix[2];
      end
      for (int i = 0; i < NumChan; i++) begin
         unique case (in_item.mode)
            ModeApprox: num_in[i] = 16'(in_item.mix[i]) * 16'(in_item.bright);
            ModeMax:    num_in[i] = {in_item.mix[i], 8'h00} - 16'(in_item.mix[i]);
            default:    num_in[i] = '0;
         endcase
      end
   end

   // stage 2: divide by 255, and upper four quotient bits of the max divide
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         scale_prod[i] = Div255ProdWidth'(b1_num_ff[i]) * Div255ProdWidth'(Div255Recip);
         apx_in[i]     = scale_prod[i][Div255Shift +: 8];
         hi_step[i]    = div_steps(b1_num_ff[i][15:8], b1_num_ff[i][7:4], b1_max_ff);
         rem_in[i]     = hi_step[i][11:4];
         qhi_in[i]     = hi_step[i][3:0];
         nlo_in[i]     = b1_num_ff[i][3:0];
      end
   end

   // stage 3: lower four quotient bits, pick the value for the mode
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         lo_step[i] = div_steps(b2_rem_ff[i], b2_nlo_ff[i], b2_max_ff);
         unique case (b2_mode_ff)
            ModeApprox: val_in[i] = b2_apx_ff[i];
            ModeMax:    val_in[i] = (b2_max_ff == '0) ? 8'd0
                                                      : {b2_qhi_ff[i], lo_step[i][3:0]};
            default:    val_in[i] = '0;
         endcase
      end
   end

   // stage 4: max-mode video scaling keeps nonzero channels lit unless brightness is zero
   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         video_prod[i] = 16'(b3_val_ff[i]) * 16'(b3_bright_ff);
         unique case (b3_mode_ff)
            ModeApprox: out_in[i] = b3_val_ff[i];
            ModeMax:    out_in[i] = (b3_val_ff[i] == '0 || b3_bright_ff == '0)
                                    ? 8'd0 : video_prod[i][15:8] + 8'd1;
            default:    out_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
         b3_valid_ff <= b3_valid_in;
         b4_valid_ff <= b4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         b1_mode_ff   <= in_item.mode;
         b1_bright_ff <= in_item.bright;
         b1_num_ff    <= num_in;
         b1_max_ff    <= max_in;
      end
      if (rdy2) begin
         b2_mode_ff   <= b1_mode_ff;
         b2_bright_ff <= b1_bright_ff;
         b2_max_ff    <= b1_max_ff;
         b2_apx_ff    <= apx_in;
         b2_rem_ff    <= rem_in;
         b2_qhi_ff    <= qhi_in;
         b2_nlo_ff    <= nlo_in;
      end
      if (rdy3) begin
         b3_mode_ff   <= b2_mode_ff;
         b3_bright_ff <= b2_bright_ff;
         b3_val_ff    <= val_in;
      end
      if (rdy4) begin
         b4_out_ff <= out_in;
      end
   end

   assign rsp_valid = b4_valid_ff;
   assign rsp_red   = b4_out_ff[0];
   assign rsp_green = b4_out_ff[1];
   assign rsp_blue  = b4_out_ff[2];

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for kelvin_to_rgb_color: directed table, then random pixels
// checked against an in-bench color predictor. Depends on ktrgb_pkg and the RTL.
`default_nettype none

module tb_top;
   import ktrgb_pkg::*;

   // one result pixel, field order as on the rsp_ ports
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct {
      ktrgb_mode_type mode;
      logic [15:0]    kelvin;
      logic [7:0]     bright;
      bit             typed;
      pixel_rgb_type  want;
   } pixel_case_type;

   // color endpoints and clamp bounds, kept apart from the package copies
   localparam int unsigned TempLow  = 2700;
   localparam int unsigned TempHigh = 6500;
   localparam int unsigned TempSpan = TempHigh - TempLow;
   localparam int unsigned WarmRgb [3] = '{255, 180, 100};
   localparam int unsigned CoolRgb [3] = '{205, 225, 255};

   localparam int NumRandom   = 1650;
   localparam int NumDirected = 22;
   localparam int IdlePct     = 22;
   localparam int HoldCycles  = 80;
   localparam int DrainCycles = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [15:0] req_kelvin = '0;
   logic [7:0]  req_brightness = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   pixel_rgb_type color_due [$];   // predicted colors, oldest first
   int            pixels_checked = 0;
   int            mismatch_count = 0;
   bit            calm = 1'b0;     // no idling on either side while set
   bit            hold_on = 1'b0;  // receiver holds off for the pressure test

   // extremes, clamp edges, both modes, zero and unit brightness
   pixel_case_type directed_cases [NumDirected] = '{
      '{ModeApprox, 16'd0,     8'd255, 1'b1, '{8'd255, 8'd180, 8'd100}},
      '{ModeApprox, 16'd65535, 8'd255, 1'b1, '{8'd205, 8'd225, 8'd255}},
      '{ModeApprox, 16'd4600,  8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd2700,  8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd0,     8'd255, 1'b1, '{8'd255, 8'd180, 8'd100}},
      '{ModeMax,    16'd65535, 8'd255, 1'b1, '{8'd205, 8'd225, 8'd255}},
      '{ModeMax,    16'd4600,  8'd1,   1'b1, '{8'd1,   8'd1,   8'd1}},
      '{ModeApprox, 16'd2699,  8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd2700,  8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd2701,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd6499,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd6500,  8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd6501,  8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'd4600,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd2701,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd6499,  8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd4600,  8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd3000,  8'd2,   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'h5555,  8'hAA,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'hAAAA,  8'h55,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeApprox, 16'h8000,  8'h80,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{ModeMax,    16'd1,     8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}}
   };

   kelvin_to_rgb_color uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_kelvin     (req_kelvin),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #10 clock = ~clock;

   // Color predictor. Clamp the temperature, blend warm and cool endpoints
   // with round-to-nearest over the span, then either scale by brightness
   // (approximate) or stretch to a peak of 255 and video-scale (maximum).
   function automatic pixel_rgb_type kelvin_pixel(ktrgb_mode_type mode,
                                                  logic [15:0] kelvin,
                                                  logic [7:0] bright);
      int unsigned   temp, cool_wt, warm_wt, peak, v;
      int unsigned   mix [3];
      int unsigned   chan [3];
      pixel_rgb_type px;
      temp = kelvin;
      if (temp < TempLow) temp = TempLow;
      if (temp > TempHigh) temp = TempHigh;
      cool_wt = temp - TempLow;
      warm_wt = TempSpan - cool_wt;
      for (int i = 0; i < 3; i++)
         mix[i] = (WarmRgb[i] * warm_wt + CoolRgb[i] * cool_wt + TempSpan / 2) / TempSpan;
      peak = mix[0];
      if (mix[1] > peak) peak = mix[1];
      if (mix[2] > peak) peak = mix[2];
      for (int i = 0; i < 3; i++) begin
         if (mode == ModeApprox) begin
            chan[i] = (mix[i] * bright) / 255;
         end else if (peak == 0) begin
            chan[i] = 0;   // black when nothing to stretch
         end else begin
            v = ((mix[i] * 255) / peak) & 8'hFF;
            // video scaling: nonzero stays nonzero unless brightness is zero
            chan[i] = (v == 0 || bright == 0) ? 0 : ((v * bright) >> 8) + 1;
         end
      end
      px.red   = chan[0][7:0];
      px.green = chan[1][7:0];
      px.blue  = chan[2][7:0];
      return px;
   endfunction

   // Offer one pixel, with random idle cycles in front of it unless calm.
   // Idle cycles carry junk payload with valid low. Returns once the
   // transaction is taken (valid high, stall low at a rising edge).
   task automatic send_pixel(ktrgb_mode_type mode, logic [15:0] kelvin,
                             logic [7:0] bright, pixel_rgb_type want);
      while (!calm && $urandom_range(99) < IdlePct) begin
         req_valid      <= 1'b0;
         req_type       <= 1'($urandom_range(1));
         req_kelvin     <= 16'($urandom);
         req_brightness <= 8'($urandom);
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= mode;
      req_kelvin     <= kelvin;
      req_brightness <= bright;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      color_due.push_back(want);
   endtask

   // Compare one accepted result with the oldest prediction.
   task automatic check_pixel(pixel_rgb_type got);
      pixel_rgb_type want;
      if (color_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
         want = color_due.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        pixels_checked, want.red, want.green, want.blue,
                        got.red, got.green, got.blue);
         end
      end
      pixels_checked++;
   endtask

   // Result side: take a transaction on each edge with valid high and stall
   // low, then pick the stall for the next cycle (hold-off, or random idling).
   initial begin
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            check_pixel('{rsp_red, rsp_green, rsp_blue});
         rsp_stall <= hold_on || (!calm && $urandom_range(99) < IdlePct);
      end
   end

   // Back-pressure: once traffic is flowing, the receiver holds off long
   // enough to fill the back stages, the queue and the front, so that
   // req_stall must rise while the sender keeps offering.
   initial begin
      wait (pixels_checked >= 400);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Stimulus: reset, the directed table, then random pixels.
   initial begin
      pixel_case_type row;
      ktrgb_mode_type mode;
      logic [15:0]    kelvin;
      logic [7:0]     bright;
      int             pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumDirected; i++) begin
         row = directed_cases[i];
         send_pixel(row.mode, row.kelvin, row.bright,
                    row.typed ? row.want : kelvin_pixel(row.mode, row.kelvin, row.bright));
      end

      // Random part: mostly temperatures around the clamp window, some over
      // the whole 16-bit range, some pinned to the clamp edges.
      for (int n = 0; n < NumRandom; n++) begin
         calm <= (n >= 700 && n < 1000);
         mode = ktrgb_mode_type'($urandom_range(1));
         pick = $urandom_range(99);
         if (pick < 70)
            kelvin = 16'($urandom_range(6600, 2600));
         else if (pick < 85)
            kelvin = 16'($urandom);
         else if (pick < 92)
            kelvin = 16'($urandom_range(1) ? TempLow : TempHigh);
         else if ($urandom_range(1))
            kelvin = 16'($urandom_range(2710, 2690));
         else
            kelvin = 16'($urandom_range(6510, 6490));
         pick = $urandom_range(99);
         if (pick < 4)
            bright = 8'd0;
         else if (pick < 8)
            bright = 8'd255;
         else if (pick < 11)
            bright = 8'd1;
         else
            bright = 8'($urandom);
         send_pixel(mode, kelvin, bright, kelvin_pixel(mode, kelvin, bright));
      end
      calm <= 1'b0;
      req_valid <= 1'b0;

      // drain, then allow a few more cycles to catch stray results
      while (color_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && color_due.size() == 0) begin
         $display("kelvin_to_rgb_color test passed");
      end else begin
         $display("kelvin_to_rgb_color test failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("kelvin_to_rgb_color test failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/ktrgb_pkg.sv
rtl/core/ktrgb_front.sv
rtl/core/ktrgb_queue.sv
rtl/core/ktrgb_back.sv
rtl/core/kelvin_to_rgb_color.sv
verif/tb_top.sv
